// ===== sv/csrc_pkg.sv =====
package csrc_pkg;

  localparam int CW = 16;           // coordinate width
  localparam int SZW = CW - 1;      // radius / size width
  localparam int PB = 16;           // projection fraction bits
  localparam int TW = PB + 1;       // t, 0 .. 2^PB
  localparam int DW = CW + 2;       // coordinate differences
  localparam int PW = 2 * DW;       // products of differences
  localparam int SW = PW + 1;       // sums of two products
  localparam int RW = SW + 1;       // divider remainder
  localparam int VW = DW + PB + 3;  // scaled offset to nearest point
  localparam int MW = 2 * CW + 2;   // magnitude of that offset
  localparam int HW = MW / 2;       // half of the magnitude, for split squaring
  localparam int QW = 2 * MW + 2;   // exact squared distance

  localparam logic KIND_SEG  = 1'b0;
  localparam logic KIND_RECT = 1'b1;

  localparam logic [TW-1:0] T_ONE_VAL = TW'(1) << PB;

  typedef enum logic [1:0] {
    T_ZERO,
    T_ONE,
    T_DIV
  } tcls_t;

  typedef struct packed {
    logic                 ehit;
    logic                 len0;
    tcls_t                tcls;
    logic signed [DW-1:0] offx;
    logic signed [DW-1:0] offy;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [PW-1:0]        r2;
  } side_t;

  function automatic logic signed [DW-1:0] sext(input logic [CW-1:0] v);
    return {{(DW - CW){v[CW-1]}}, v};
  endfunction

  function automatic logic signed [DW-1:0] zext(input logic [SZW-1:0] v);
    return {{(DW - SZW){1'b0}}, v};
  endfunction

endpackage

// ===== sv/csrc_div.sv =====
module csrc_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [csrc_pkg::RW-1:0] in_rem,
  input  logic [csrc_pkg::RW-1:0] in_den,
  input  csrc_pkg::side_t        in_side,
  output logic                   out_valid,
  output logic [csrc_pkg::PB-1:0] out_q,
  output logic [csrc_pkg::RW-1:0] out_den,
  output csrc_pkg::side_t        out_side
);

  // one quotient bit per stage, restoring
  logic [csrc_pkg::RW-1:0] rem [csrc_pkg::PB];
  logic [csrc_pkg::RW-1:0] den [csrc_pkg::PB];
  logic [csrc_pkg::PB-1:0] q   [csrc_pkg::PB];
  logic                    v   [csrc_pkg::PB];
  csrc_pkg::side_t         sd  [csrc_pkg::PB];

  for (genvar i = 0; i < csrc_pkg::PB; i++) begin : g_stage
    logic [csrc_pkg::RW-1:0] rem_in, den_in, sh;
    logic [csrc_pkg::PB-1:0] q_in;
    logic                    v_in, ge;
    csrc_pkg::side_t         sd_in;

    if (i == 0) begin : g_first
      assign rem_in = in_rem;
      assign den_in = in_den;
      assign q_in   = '0;
      assign v_in   = in_valid;
      assign sd_in  = in_side;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign den_in = den[i-1];
      assign q_in   = q[i-1];
      assign v_in   = v[i-1];
      assign sd_in  = sd[i-1];
    end

    assign sh = {rem_in[csrc_pkg::RW-2:0], 1'b0};
    assign ge = sh >= den_in;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? sh - den_in : sh;
        den[i] <= den_in;
        q[i]   <= {q_in[csrc_pkg::PB-2:0], ge};
        sd[i]  <= sd_in;
      end
    end
  end

  assign out_valid = v[csrc_pkg::PB-1];
  assign out_q     = q[csrc_pkg::PB-1];
  assign out_den   = den[csrc_pkg::PB-1];
  assign out_side  = sd[csrc_pkg::PB-1];

endmodule

// ===== sv/circle_segment_rectangle_collision.sv =====
// Circle collision tester. Each input word asks one question and gets one
// output word with a hit bit. tuser selects the test: 0 circle versus line
// segment, 1 circle versus axis-aligned rectangle. Coordinates are signed
// Q12.4; the boundary counts as a hit; endpoint and rectangle tests are exact.
// One word is accepted every cycle unless the output stalls. The pipeline
// has 4 setup stages, a 16-stage one-bit-per-stage divider for the
// projection factor t, 5 stages of t products, nearest-point offset,
// magnitudes and exact squaring, and the output register that takes the
// compare. A stall on the output holds the whole pipeline.
module circle_segment_rectangle_collision (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // center_x, center_y, circle_radius, seg_start_x, seg_start_y, seg_end_x,
  // seg_end_y, rect_left, rect_top, rect_width, rect_height
  input  logic [175:0] s_tdata,
  // kind
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit
  output logic [7:0]   m_tdata
);

  localparam int DW = csrc_pkg::DW;
  localparam int PW = csrc_pkg::PW;
  localparam int SW = csrc_pkg::SW;
  localparam int RW = csrc_pkg::RW;
  localparam int VW = csrc_pkg::VW;
  localparam int MW = csrc_pkg::MW;
  localparam int HW = csrc_pkg::HW;
  localparam int QW = csrc_pkg::QW;
  localparam int PB = csrc_pkg::PB;
  localparam int TW = csrc_pkg::TW;

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // ---------------- stage 1: differences, rectangle clamp
  logic signed [DW-1:0] cx, cy, sx, sy, ex, ey, rl, rt, rr, rb, qx, qy;
  logic [csrc_pkg::SZW-1:0] rad;
  assign cx  = csrc_pkg::sext(s_tdata[15:0]);
  assign cy  = csrc_pkg::sext(s_tdata[31:16]);
  assign rad = s_tdata[46:32];
  assign sx  = csrc_pkg::sext(s_tdata[62:47]);
  assign sy  = csrc_pkg::sext(s_tdata[78:63]);
  assign ex  = csrc_pkg::sext(s_tdata[94:79]);
  assign ey  = csrc_pkg::sext(s_tdata[110:95]);
  assign rl  = csrc_pkg::sext(s_tdata[126:111]);
  assign rt  = csrc_pkg::sext(s_tdata[142:127]);
  assign rr  = rl + csrc_pkg::zext(s_tdata[157:143]);
  assign rb  = rt + csrc_pkg::zext(s_tdata[172:158]);
  assign qx  = (cx < rl) ? rl : ((cx > rr) ? rr : cx);
  assign qy  = (cy < rt) ? rt : ((cy > rb) ? rb : cy);

  logic v1, k1;
  logic [csrc_pkg::SZW-1:0] r1;
  logic signed [DW-1:0] e0x1, e0y1, e1x1, e1y1, dx1, dy1, ox1, oy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1   <= s_tuser;
      r1   <= rad;
      e0x1 <= (s_tuser == csrc_pkg::KIND_RECT) ? cx - qx : sx - cx;
      e0y1 <= (s_tuser == csrc_pkg::KIND_RECT) ? cy - qy : sy - cy;
      e1x1 <= ex - cx;
      e1y1 <= ey - cy;
      dx1  <= ex - sx;
      dy1  <= ey - sy;
      ox1  <= cx - sx;
      oy1  <= cy - sy;
    end
  end

  // ---------------- stage 2: products
  logic v2, k2;
  logic signed [PW-1:0] p0x, p0y, p1x, p1y, pdx, pdy, pox, poy;
  logic [PW-1:0] r2_2;
  logic signed [DW-1:0] dx2, dy2, ox2, oy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k2   <= k1;
      p0x  <= e0x1 * e0x1;
      p0y  <= e0y1 * e0y1;
      p1x  <= e1x1 * e1x1;
      p1y  <= e1y1 * e1y1;
      pdx  <= dx1 * dx1;
      pdy  <= dy1 * dy1;
      pox  <= ox1 * dx1;
      poy  <= oy1 * dy1;
      r2_2 <= PW'(r1) * PW'(r1);
      dx2  <= dx1;
      dy2  <= dy1;
      ox2  <= ox1;
      oy2  <= oy1;
    end
  end

  // ---------------- stage 3: sums
  logic v3, k3;
  logic signed [SW-1:0] d0_3, d1_3, len2_3, dot3;
  logic [PW-1:0] r2_3;
  logic signed [DW-1:0] dx3, dy3, ox3, oy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k3     <= k2;
      d0_3   <= SW'(p0x) + SW'(p0y);
      d1_3   <= SW'(p1x) + SW'(p1y);
      len2_3 <= SW'(pdx) + SW'(pdy);
      dot3   <= SW'(pox) + SW'(poy);
      r2_3   <= r2_2;
      dx3    <= dx2;
      dy3    <= dy2;
      ox3    <= ox2;
      oy3    <= oy2;
    end
  end

  // ---------------- stage 4: endpoint tests, t class
  logic signed [SW-1:0] r2s;
  logic                 len0_c;
  csrc_pkg::tcls_t      tcls_c;
  assign r2s    = $signed({1'b0, r2_3});
  assign len0_c = (len2_3 == '0) || (k3 == csrc_pkg::KIND_RECT);
  // rectangle and zero-length words never run a real divide
  always_comb begin
    if (len0_c || (dot3 <= 0)) begin
      tcls_c = csrc_pkg::T_ZERO;
    end else if (dot3 >= len2_3) begin
      tcls_c = csrc_pkg::T_ONE;
    end else begin
      tcls_c = csrc_pkg::T_DIV;
    end
  end

  logic            v4;
  logic [RW-1:0]   rem4, den4;
  csrc_pkg::side_t sd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd4.ehit <= (d0_3 <= r2s) || ((k3 == csrc_pkg::KIND_SEG) && (d1_3 <= r2s));
      sd4.len0 <= len0_c;
      sd4.tcls <= tcls_c;
      sd4.offx <= ox3;
      sd4.offy <= oy3;
      sd4.dx   <= dx3;
      sd4.dy   <= dy3;
      sd4.r2   <= r2_3;
      rem4     <= (tcls_c == csrc_pkg::T_DIV) ? RW'(unsigned'(dot3)) : '0;
      den4     <= RW'(unsigned'(len2_3));
    end
  end

  // ---------------- divider
  logic            vd;
  logic [PB-1:0]   qd;
  logic [RW-1:0]   dend;
  csrc_pkg::side_t sdd;

  csrc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v4),
    .in_rem   (rem4),
    .in_den   (den4),
    .in_side  (sd4),
    .out_valid(vd),
    .out_q    (qd),
    .out_den  (dend),
    .out_side (sdd)
  );

  logic [TW-1:0] tval;
  always_comb begin
    unique case (sdd.tcls)
      csrc_pkg::T_ZERO: tval = '0;
      csrc_pkg::T_ONE:  tval = csrc_pkg::T_ONE_VAL;
      default:          tval = {1'b0, qd};
    endcase
  end

  // ---------------- m1: t products
  logic            vm1;
  csrc_pkg::side_t sm1;
  logic signed [PW-1:0] tpx, tpy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1 <= 1'b0;
    end else if (adv) begin
      vm1 <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm1 <= sdd;
      tpx <= sdd.dx * $signed({1'b0, tval});
      tpy <= sdd.dy * $signed({1'b0, tval});
    end
  end

  // ---------------- m2: scaled offset to nearest point
  logic            vm2;
  csrc_pkg::side_t sm2;
  logic signed [VW-1:0] vx, vy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm2 <= 1'b0;
    end else if (adv) begin
      vm2 <= vm1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm2 <= sm1;
      vx  <= {{(VW - DW - PB){sm1.offx[DW-1]}}, sm1.offx, {PB{1'b0}}}
             - {{(VW - PW){tpx[PW-1]}}, tpx};
      vy  <= {{(VW - DW - PB){sm1.offy[DW-1]}}, sm1.offy, {PB{1'b0}}}
             - {{(VW - PW){tpy[PW-1]}}, tpy};
    end
  end

  // ---------------- m3: magnitudes
  logic            vm3;
  csrc_pkg::side_t sm3;
  logic [MW-1:0]   mx, my;
  logic signed [VW-1:0] nx, ny;
  assign nx = -vx;
  assign ny = -vy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm3 <= 1'b0;
    end else if (adv) begin
      vm3 <= vm2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm3 <= sm2;
      mx  <= vx[VW-1] ? nx[MW-1:0] : vx[MW-1:0];
      my  <= vy[VW-1] ? ny[MW-1:0] : vy[MW-1:0];
    end
  end

  // ---------------- m4: split squaring, partial products
  logic            vm4;
  csrc_pkg::side_t sm4;
  logic [2*HW-1:0] xhh, xhl, xll, yhh, yhl, yll;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm4 <= 1'b0;
    end else if (adv) begin
      vm4 <= vm3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm4 <= sm3;
      xhh <= mx[MW-1:HW] * mx[MW-1:HW];
      xhl <= mx[MW-1:HW] * mx[HW-1:0];
      xll <= mx[HW-1:0] * mx[HW-1:0];
      yhh <= my[MW-1:HW] * my[MW-1:HW];
      yhl <= my[MW-1:HW] * my[HW-1:0];
      yll <= my[HW-1:0] * my[HW-1:0];
    end
  end

  // ---------------- m5: per-axis squares
  logic            vm5;
  csrc_pkg::side_t sm5;
  logic [QW-1:0]   sqx, sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm5 <= 1'b0;
    end else if (adv) begin
      vm5 <= vm4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm5 <= sm4;
      sqx <= (QW'(xhh) << (2 * HW)) + (QW'(xhl) << (HW + 1)) + QW'(xll);
      sqy <= (QW'(yhh) << (2 * HW)) + (QW'(yhl) << (HW + 1)) + QW'(yll);
    end
  end

  // ---------------- m6: compare against (r << PB)^2, output word
  logic close;
  assign close = (sqx + sqy) <= (QW'(sm5.r2) << (2 * PB));

  logic hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vm5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit <= sm5.ehit || (!sm5.len0 && close);
    end
  end

  assign m_tdata = {7'b0, hit};

`ifndef SYNTHESIS
  a_stall_only_on_full_output : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while output free");

  a_div_class_has_length : assert property (@(posedge clk) disable iff (rst)
    (vd && (sdd.tcls == csrc_pkg::T_DIV)) |-> (!sdd.len0 && (dend != '0)))
    else $error("projection divide on zero-length or rectangle word");

  a_hold_on_stall : assert property (@(posedge clk) disable iff (rst)
    (vm5 && m_tvalid && !m_tready) |=> vm5)
    else $error("pipeline word lost during stall");
`endif

endmodule
